// ===== hw/rtl/crm_pkg.sv =====
// ----------------------------------------------------------------------------
// crm_pkg
// Shared types for the cyclic rotation match block: transaction payloads and
// the sequencer state.
// ----------------------------------------------------------------------------
`default_nettype none

package crm_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned ShiftW = 7;

  typedef struct packed {
    logic signed [ValueW-1:0] a_value;
    logic signed [ValueW-1:0] b_value;
    logic                     last;
  } crm_in_t;

  typedef struct packed {
    logic              is_rotation;
    logic [ShiftW-1:0] shift;
    logic              length_error;
  } crm_out_t;

  typedef enum logic {
    ST_LOAD,
    ST_SEARCH
  } crm_state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/cyclic_rotation_match.sv =====
// ----------------------------------------------------------------------------
// cyclic_rotation_match
// Stores two sequences A and B pair by pair, then finds the smallest right
// rotation s with A[(s+j) mod n] == B[j] for all j.
// ----------------------------------------------------------------------------
// Pairs load at one transaction per cycle into two DEPTH x 32 memories. After
// the final pair the block stops accepting input and walks shifts 0..n-1,
// comparing one element of each memory per cycle through the single read
// port of each memory, whose read data is registered. A shift is abandoned
// at its first mismatch, dropping the read in flight, and the next shift is
// tried. A sequence longer than DEPTH is flagged with length_error and no
// search is run. A final pair is held off while an earlier result still
// waits on the output; other pairs are taken meanwhile. No clearing pass is
// needed after reset.
`default_nettype none

module cyclic_rotation_match
  import crm_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire crm_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output crm_out_t      out_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Sequence stores
  logic [ValueW-1:0] mem_a [DEPTH];
  logic [ValueW-1:0] mem_b [DEPTH];
  logic [ValueW-1:0] rd_a_q, rd_b_q;

  crm_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] n_q, n_d;
  logic          ovf_q, ovf_d;
  logic [AW-1:0] s_q, s_d, j_q, j_d, k_q, k_d;
  logic          iss_q, iss_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic          cmp_last_q, cmp_last_d;
  logic          out_vld_q, out_vld_d;
  crm_out_t      out_q, out_d;

  logic          in_acc;
  logic          full;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] n_last;
  logic          mismatch;

  assign full       = (cnt_q == CW'(DEPTH));
  assign in_ready_o = (state_q == ST_LOAD) && (!in_data_i.last || !out_vld_q);
  assign in_acc     = in_valid_i && in_ready_o;
  assign wr_en      = in_acc && !full;
  assign wr_addr    = cnt_q[AW-1:0];
  assign n_last     = n_q - CW'(1);
  assign mismatch   = cmp_vld_q && (rd_a_q != rd_b_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_a[wr_addr] <= in_data_i.a_value;
    end
    rd_a_q <= mem_a[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_b[wr_addr] <= in_data_i.b_value;
    end
    rd_b_q <= mem_b[j_q];
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    n_d        = n_q;
    ovf_d      = ovf_q;
    s_d        = s_q;
    j_d        = j_q;
    k_d        = k_q;
    iss_d      = iss_q;
    cmp_vld_d  = 1'b0;
    cmp_last_d = cmp_last_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_d      = out_q;

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
          if (in_data_i.last) begin
            cnt_d = '0;
            ovf_d = 1'b0;
            if (ovf_q || full) begin
              out_vld_d          = 1'b1;
              out_d.is_rotation  = 1'b0;
              out_d.shift        = '0;
              out_d.length_error = 1'b1;
            end else begin
              // Start at shift 0, first element
              state_d = ST_SEARCH;
              n_d     = cnt_q + CW'(1);
              s_d     = '0;
              j_d     = '0;
              k_d     = '0;
              iss_d   = 1'b1;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (mismatch) begin
          // Drop the read in flight and try the next shift, or report no rotation after the last
          if (CW'(s_q) + CW'(1) == n_q) begin
            state_d            = ST_LOAD;
            out_vld_d          = 1'b1;
            out_d.is_rotation  = 1'b0;
            out_d.shift        = '0;
            out_d.length_error = 1'b0;
          end else begin
            s_d   = s_q + AW'(1);
            j_d   = '0;
            k_d   = s_q + AW'(1);
            iss_d = 1'b1;
          end
        end else if (cmp_vld_q && cmp_last_q) begin
          state_d            = ST_LOAD;
          out_vld_d          = 1'b1;
          out_d.is_rotation  = 1'b1;
          out_d.shift        = ShiftW'(s_q);
          out_d.length_error = 1'b0;
        end else if (iss_q) begin
          cmp_vld_d  = 1'b1;
          cmp_last_d = (CW'(j_q) == n_last);
          iss_d      = (CW'(j_q) != n_last);
          j_d        = j_q + AW'(1);
          k_d        = (CW'(k_q) == n_last) ? '0 : k_q + AW'(1);
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      iss_q     <= 1'b0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      iss_q     <= iss_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    s_q        <= s_d;
    j_q        <= j_d;
    k_q        <= k_d;
    cmp_last_q <= cmp_last_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Fill count never passes the store depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("pair count beyond depth");

  // The A read address and the shift stay inside the loaded sequence
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (CW'(k_q) < n_q) && (CW'(s_q) < n_q))
    else $error("search address beyond sequence length");

  // A search ends with a result and a return to loading
  a_search_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH && state_d == ST_LOAD) |=> out_vld_q)
    else $error("search finished without a result");

  // A match is never reported together with a length error
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.is_rotation && out_q.length_error))
    else $error("match and length error both set");

endmodule

`default_nettype wire

// ===== tb/cyclic_rotation_match_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyclic_rotation_match_tb
// Loads pairs of sequences into the rotation matcher and checks each verdict
// against a software search over the same sequences. Directed cases cover
// single pairs, the longest legal sequence, the largest shift, periodic data
// and an over-long sequence. Random sequences follow, mostly true rotations
// with random content, some with one element corrupted and some unrelated.
// Both handshakes idle in random bursts.
// ----------------------------------------------------------------------------

module cyclic_rotation_match_tb
  import crm_pkg::*;
();

  localparam int unsigned Depth      = 128;
  localparam int unsigned ItemTarget = 1150;
  localparam int unsigned QuietItems = 150;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned TailCycles = 64;
  localparam int unsigned ReportMax  = 10;

  typedef logic [ValueW-1:0] word_q_t[$];

  // Expected verdicts, worked out from the pairs seen at the input.
  class rotation_scoreboard;
    logic [ValueW-1:0] seq_a[Depth];
    logic [ValueW-1:0] seq_b[Depth];
    int unsigned       pair_count    = 0;
    bit                overflow_seen = 1'b0;
    crm_out_t          verdicts_due[$];
    int unsigned       mismatches    = 0;

    function void note_pair(crm_in_t pair);
      crm_out_t    verdict;
      bit          hit;
      int unsigned k;
      if (pair_count < Depth) begin
        seq_a[pair_count] = pair.a_value;
        seq_b[pair_count] = pair.b_value;
        pair_count++;
      end else begin
        overflow_seen = 1'b1;
      end
      if (!pair.last) return;
      verdict              = '0;
      verdict.length_error = overflow_seen;
      if (!overflow_seen) begin
        // take the first shift s with A[(s+j) mod n] == B[j] for all j
        for (int unsigned s = 0; s < pair_count && !verdict.is_rotation; s++) begin
          hit = 1'b1;
          k   = s;
          for (int unsigned j = 0; j < pair_count && hit; j++) begin
            if (seq_a[k] != seq_b[j]) hit = 1'b0;
            k = (k + 1 == pair_count) ? 0 : k + 1;
          end
          if (hit) begin
            verdict.is_rotation = 1'b1;
            verdict.shift       = ShiftW'(s);
          end
        end
      end
      verdicts_due.push_back(verdict);
      pair_count    = 0;
      overflow_seen = 1'b0;
    endfunction

    function void check_verdict(crm_out_t got);
      crm_out_t want;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected verdict: rot=%0b shift=%0d lerr=%0b",
                   got.is_rotation, got.shift, got.length_error);
        return;
      end
      want = verdicts_due.pop_front();
      if (got.is_rotation !== want.is_rotation || got.shift !== want.shift ||
          got.length_error !== want.length_error) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("mismatch: expected rot=%0b shift=%0d lerr=%0b, got rot=%0b shift=%0d lerr=%0b",
                   want.is_rotation, want.shift, want.length_error,
                   got.is_rotation, got.shift, got.length_error);
      end
    endfunction

    function int unsigned outstanding();
      return verdicts_due.size();
    endfunction
  endclass

  logic     clk_i     = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  crm_in_t  in_data   = '0;
  logic     out_ready = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  crm_out_t out_data_o;

  rotation_scoreboard sb;
  int unsigned        items_sent = 0;
  bit                 quiet      = 1'b0;

  cyclic_rotation_match #(
    .DEPTH (Depth)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Note every transaction on both channels at the edge where it happens.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready_o) sb.note_pair(in_data);
      if (out_valid_o && out_ready) sb.check_verdict(out_data_o);
    end
  end

  // Result side: stall in bursts, none once the run goes quiet.
  initial begin
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("cyclic_rotation_match_tb: errors");
    $finish;
  end

  function automatic word_q_t rotated(word_q_t src, int unsigned amount);
    word_q_t dst = src;
    foreach (src[j]) dst[(amount + j) % src.size()] = src[j];
    return dst;
  endfunction

  task automatic push_pair(input crm_in_t pair);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= pair;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_sequence(input word_q_t a_q, input word_q_t b_q);
    crm_in_t pair;
    foreach (a_q[i]) begin
      pair.a_value = a_q[i];
      pair.b_value = b_q[i];
      pair.last    = (i == a_q.size() - 1);
      push_pair(pair);
    end
    items_sent += a_q.size();
  endtask

  // Hold the input until every verdict owed has been taken.
  task automatic drain_verdicts();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  initial begin
    word_q_t     a_q;
    word_q_t     b_q;
    word_q_t     pattern;
    int unsigned n;
    int unsigned pick;
    int unsigned content_mode;

    sb = new;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // single pairs at the extremes
    a_q = '{32'h8000_0000};
    send_sequence(a_q, a_q);
    a_q = '{32'h7FFF_FFFF};
    b_q = '{32'h8000_0000};
    send_sequence(a_q, b_q);
    a_q = '{32'hFFFF_FFFF};
    send_sequence(a_q, a_q);
    a_q = '{32'h0000_0000};
    send_sequence(a_q, a_q);
    // swapped pair, then three elements that never line up
    b_q = '{32'h7FFF_FFFF, 32'h8000_0000};
    send_sequence(rotated(b_q, 1), b_q);
    a_q = '{32'd5, 32'd6, 32'd7};
    b_q = '{32'd5, 32'd7, 32'd6};
    send_sequence(a_q, b_q);
    // constant and periodic data: the smallest shift wins
    a_q = '{4{32'h5555_5555}};
    send_sequence(a_q, a_q);
    b_q = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555};
    send_sequence(rotated(b_q, 3), b_q);
    // full store with the largest shift, then one pair too many
    b_q.delete();
    for (int unsigned j = 0; j < Depth; j++) b_q.push_back((j * 32'h0101_0101) ^ 32'hC3C3_0000);
    send_sequence(rotated(b_q, Depth - 1), b_q);
    b_q.push_back($urandom);
    send_sequence(b_q, b_q);
    a_q = '{32'h1234_5678};
    send_sequence(a_q, a_q);
    drain_verdicts();

    while (items_sent < ItemTarget) begin
      quiet = (items_sent + QuietItems >= ItemTarget);
      pick  = $urandom_range(0, 99);
      if (pick < 70)      n = $urandom_range(1, 8);
      else if (pick < 93) n = $urandom_range(9, 24);
      else if (pick < 98) n = $urandom_range(25, Depth);
      else                n = $urandom_range(Depth + 1, Depth + 6);

      // B: full-range words, a small alphabet, or a short repeating pattern
      pattern.delete();
      repeat ($urandom_range(1, 3)) pattern.push_back($urandom);
      content_mode = $urandom_range(0, 2);
      b_q.delete();
      for (int unsigned j = 0; j < n; j++) begin
        case (content_mode)
          0:       b_q.push_back($urandom);
          1:       b_q.push_back(pattern[$urandom_range(0, pattern.size() - 1)]);
          default: b_q.push_back(pattern[j % pattern.size()]);
        endcase
      end

      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        a_q = rotated(b_q, $urandom_range(0, n - 1));
        // spoil one bit of one element
        if (pick >= 60) a_q[$urandom_range(0, n - 1)] ^= 32'h1 << $urandom_range(0, 31);
      end else begin
        a_q.delete();
        for (int unsigned j = 0; j < n; j++)
          a_q.push_back(pick < 90 ? $urandom : pattern[$urandom_range(0, pattern.size() - 1)]);
      end

      send_sequence(a_q, b_q);
      if (!quiet && $urandom_range(0, 19) == 0) drain_verdicts();
    end
    drain_verdicts();
    repeat (TailCycles) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("cyclic_rotation_match_tb: clean");
    end else begin
      $display("cyclic_rotation_match_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/crm_pkg.sv
hw/rtl/cyclic_rotation_match.sv
tb/cyclic_rotation_match_tb.sv
